### rtl/ipv4l4_pkg.sv
// ----------------------------------------------------------------------------
// ipv4l4_pkg
// Shared constants and types for the IPv4 / TCP / UDP header extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv4l4_pkg;

    // capture limit; bytes past it are dropped and the length saturates
    localparam int SNAP_BYTES = 256;
    localparam int POS_W      = $clog2(SNAP_BYTES + 1);

    localparam int ETH_HDR   = 14;
    localparam int IP_MIN    = 20;
    localparam int IP_END    = 34;   // Ethernet header plus minimum IP header
    localparam int TCP_MIN   = 20;
    localparam int UDP_MIN   = 8;
    localparam int FLAG_OFS  = 13;   // TCP flag byte within the L4 header

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    typedef logic [POS_W-1:0] t_pos;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT_ETH = 3'd1,
        ST_NOT_IPV4  = 3'd2,
        ST_SHORT_IP  = 3'd3,
        ST_BAD_IHL   = 3'd4,
        ST_SHORT_OPT = 3'd5,
        ST_L4_TRUNC  = 3'd6
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  protocol;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] frame_len;
        logic [5:0]  tcp_flags;
        logic [31:0] frame_num;
    } t_result;

    // one frame byte handed from the input register to the capture logic
    typedef struct packed {
        logic        valid;
        logic [7:0]  data;
        logic        last;
        logic [15:0] wire_len;
    } t_byte;

endpackage

`default_nettype wire

### rtl/ipv4_l4_header_extractor_top.sv
// ----------------------------------------------------------------------------
// ipv4_l4_header_extractor_top
// Ethernet / IPv4 / TCP / UDP header extractor, one frame byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one captured frame byte per item, wire order. tlast marks
//   the final captured byte; the wire length in tdata is used only with it.
//   Master channel: one result item per frame, issued for the tlast byte,
//   carrying the parse status (tuser) and the extracted header fields.
//   Throughput: one byte item per cycle, frame after frame, unless a last byte is held back by a pending result.
//   Pipeline: two register stages (input register, then the capture / status
//   logic into the result register).
//   Stall: a result waiting in the output register only holds back a new
//   last byte; ordinary bytes keep flowing. A stalled last byte blocks the
//   input until the result register frees up.
//   Reset: synchronous, active low; clears the frame capture state, the
//   frame counter and both valid flags. No result is pending after reset.
//   Bytes past 256 are ignored and the captured length saturates there.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_l4_header_extractor_top
    import ipv4l4_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [23:0]  i_s_axis_tdata,   // data_byte[7:0], wire_length[23:8]
    input  wire logic         i_s_axis_tlast,   // last_byte

    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // source_address[31:0], dest_address[63:32], protocol[71:64],
    // l4 sport[87:72], l4 dport[103:88], frame_length[119:104],
    // tcp_flag_bits[125:120], frame_number[157:126], zero pad[159:158]
    output logic [159:0]      o_m_axis_tdata,
    output logic [2:0]        o_m_axis_tuser    // status
);

    logic        r_in_valid;
    logic [7:0]  r_in_data;
    logic        r_in_last;
    logic [15:0] r_in_wlen;

    logic        r_out_valid;
    t_result     r_out;

    logic        proc;
    t_byte       cap_byte;
    t_result     cap_res;

    // a non-last byte never needs the result register
    assign proc = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || proc;

    assign cap_byte.valid    = proc;
    assign cap_byte.data     = r_in_data;
    assign cap_byte.last     = r_in_last;
    assign cap_byte.wire_len = r_in_wlen;

    ipv4l4_capture u_capture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (cap_byte),
        .o_result (cap_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_data <= i_s_axis_tdata[7:0];
            r_in_wlen <= i_s_axis_tdata[23:8];
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_last) begin
            r_out <= cap_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {2'b00,
                              r_out.frame_num,
                              r_out.tcp_flags,
                              r_out.frame_len,
                              r_out.dport,
                              r_out.sport,
                              r_out.protocol,
                              r_out.dst_addr,
                              r_out.src_addr};

endmodule

`default_nettype wire

### rtl/ipv4l4_capture.sv
// ----------------------------------------------------------------------------
// ipv4l4_capture
// Per-frame header capture by byte position, and the end-of-frame status
// and result fields computed from the updated capture state.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4l4_capture
    import ipv4l4_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_byte   i_byte,     // valid means the byte is consumed this cycle
    output t_result      o_result    // meaningful when the consumed byte is last
);

    t_pos        r_pos,   n_pos;
    logic [15:0] r_etype, n_etype;
    logic [3:0]  r_hw,    n_hw;
    logic [31:0] r_src,   n_src;
    logic [31:0] r_dst,   n_dst;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_ports, n_ports;
    logic [5:0]  r_flags, n_flags;
    logic [31:0] r_fcnt,  n_fcnt;

    t_pos        l4_pos;
    t_pos        hdr_end;
    logic [5:0]  hlen;
    logic [7:0]  b;

    assign b      = i_byte.data;
    assign l4_pos = POS_W'(ETH_HDR) + POS_W'({r_hw, 2'b00});

    always_comb begin
        n_pos   = r_pos;
        n_etype = r_etype;
        n_hw    = r_hw;
        n_src   = r_src;
        n_dst   = r_dst;
        n_proto = r_proto;
        n_ports = r_ports;
        n_flags = r_flags;
        if (r_pos < POS_W'(SNAP_BYTES)) begin
            n_pos = r_pos + POS_W'(1);
            if (r_pos == POS_W'(12) || r_pos == POS_W'(13)) begin
                n_etype = {r_etype[7:0], b};
            end else if (r_pos == POS_W'(ETH_HDR)) begin
                n_hw = b[3:0];
            end else if (r_pos == POS_W'(23)) begin
                n_proto = b;
            end else if (r_pos >= POS_W'(26) && r_pos < POS_W'(30)) begin
                n_src = {r_src[23:0], b};
            end else if (r_pos >= POS_W'(30) && r_pos < POS_W'(IP_END)) begin
                n_dst = {r_dst[23:0], b};
            end
            if (r_pos >= POS_W'(IP_END)) begin
                if (r_pos >= l4_pos && r_pos < l4_pos + POS_W'(4)) begin
                    n_ports = {r_ports[23:0], b};
                end
                if (r_pos == l4_pos + POS_W'(FLAG_OFS)) begin
                    n_flags = b[5:0];
                end
            end
        end
    end

    assign n_fcnt  = r_fcnt + 32'd1;
    assign hlen    = {n_hw, 2'b00};
    assign hdr_end = POS_W'(ETH_HDR) + POS_W'(hlen);

    // status decision on the state including the last byte
    always_comb begin
        o_result           = '0;
        o_result.frame_len = i_byte.wire_len;
        o_result.frame_num = n_fcnt;
        priority if (n_pos < POS_W'(ETH_HDR)) begin
            o_result.status = ST_SHORT_ETH;
        end else if (n_etype != ETYPE_IPV4) begin
            o_result.status = ST_NOT_IPV4;
        end else if (n_pos < POS_W'(IP_END)) begin
            o_result.status = ST_SHORT_IP;
        end else if (hlen < 6'(IP_MIN)) begin
            o_result.status = ST_BAD_IHL;
        end else if (n_pos < hdr_end) begin
            o_result.status = ST_SHORT_OPT;
        end else begin
            o_result.status   = ST_OK;
            o_result.src_addr = n_src;
            o_result.dst_addr = n_dst;
            o_result.protocol = n_proto;
            if (n_proto == PROTO_TCP) begin
                if (n_pos >= hdr_end + POS_W'(TCP_MIN)) begin
                    o_result.sport     = n_ports[31:16];
                    o_result.dport     = n_ports[15:0];
                    o_result.tcp_flags = n_flags;
                end else begin
                    o_result.status = ST_L4_TRUNC;
                end
            end else if (n_proto == PROTO_UDP) begin
                if (n_pos >= hdr_end + POS_W'(UDP_MIN)) begin
                    o_result.sport = n_ports[31:16];
                    o_result.dport = n_ports[15:0];
                end else begin
                    o_result.status = ST_L4_TRUNC;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_etype <= '0;
            r_hw    <= '0;
            r_src   <= '0;
            r_dst   <= '0;
            r_proto <= '0;
            r_ports <= '0;
            r_flags <= '0;
            r_fcnt  <= '0;
        end else if (i_byte.valid) begin
            if (i_byte.last) begin
                // frame done: clear per-frame capture
                r_pos   <= '0;
                r_etype <= '0;
                r_hw    <= '0;
                r_src   <= '0;
                r_dst   <= '0;
                r_proto <= '0;
                r_ports <= '0;
                r_flags <= '0;
                r_fcnt  <= n_fcnt;
            end else begin
                r_pos   <= n_pos;
                r_etype <= n_etype;
                r_hw    <= n_hw;
                r_src   <= n_src;
                r_dst   <= n_dst;
                r_proto <= n_proto;
                r_ports <= n_ports;
                r_flags <= n_flags;
            end
        end
    end

endmodule

`default_nettype wire

### tb/sv/ipv4_l4_header_extractor_top_test.sv
// ----------------------------------------------------------------------------
// ipv4_l4_header_extractor_top_test
// Streams Ethernet frames byte by byte into the header extractor and checks
// every per-frame summary, field by field, against a byte-level parser kept
// in the bench. A short table of hand-picked frames comes first, then random
// frames, mostly well-formed TCP/UDP over IPv4 with some broken and noise
// frames mixed in. Both sides stall in random bursts; once the sink holds
// off long enough for the block to back up into its input.
// ----------------------------------------------------------------------------

module ipv4_l4_header_extractor_top_test;
    import ipv4l4_pkg::*;

    localparam int ITEM_TARGET  = 1900;
    localparam int QUIET_ITEMS  = 300;   // tail of the run with no stalls
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 10;    // summaries seen before the long hold
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        int          len;
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] wire_len;
        bit          typed;
        t_status     want;
    } t_frame_spec;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [23:0]  s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tready = 1'b0;
    logic         s_tready;
    logic         m_tvalid;
    logic [159:0] m_tdata;
    logic [2:0]   m_tuser;

    ipv4_l4_header_extractor_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // data_byte[7:0], wire_length[23:8]
        .i_s_axis_tlast  (s_tlast),   // last_byte
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // addresses, protocol, ports, length, flags, number
        .o_m_axis_tuser  (m_tuser)    // status
    );

    always #4 i_clk = ~i_clk;

    // bench copy of the capture state
    logic [8:0]  cap_count;
    logic [15:0] etype_acc;
    logic [3:0]  ihl_acc;
    logic [31:0] src_acc;
    logic [31:0] dst_acc;
    logic [7:0]  proto_acc;
    logic [31:0] ports_acc;
    logic [5:0]  flags_acc;
    logic [31:0] frames_ended;

    t_result     summaries_due[$];
    logic [7:0]  frame_bytes[$];
    int          bytes_sent = 0;
    int          summaries_seen = 0;
    int          mismatch_count = 0;
    bit          quiet = 1'b0;

    t_frame_spec directed_frames[18] = '{
        '{1,   16'h0800, 4'd5,  PROTO_TCP, 16'h0000, 1'b1, ST_SHORT_ETH},
        '{13,  16'h0800, 4'd5,  PROTO_TCP, 16'hFFFF, 1'b1, ST_SHORT_ETH},
        '{14,  16'h86DD, 4'd5,  PROTO_TCP, 16'd14,   1'b1, ST_NOT_IPV4},
        '{60,  16'hFFFF, 4'd5,  PROTO_TCP, 16'd60,   1'b1, ST_NOT_IPV4},
        '{33,  16'h0800, 4'd5,  PROTO_TCP, 16'd33,   1'b1, ST_SHORT_IP},
        '{34,  16'h0800, 4'd0,  PROTO_TCP, 16'd34,   1'b1, ST_BAD_IHL},
        '{60,  16'h0800, 4'd4,  PROTO_UDP, 16'd60,   1'b1, ST_BAD_IHL},
        '{40,  16'h0800, 4'd15, PROTO_TCP, 16'd40,   1'b1, ST_SHORT_OPT},
        '{53,  16'h0800, 4'd5,  PROTO_TCP, 16'd53,   1'b0, ST_OK},
        '{54,  16'h0800, 4'd5,  PROTO_TCP, 16'd54,   1'b0, ST_OK},
        '{41,  16'h0800, 4'd5,  PROTO_UDP, 16'd41,   1'b0, ST_OK},
        '{42,  16'h0800, 4'd5,  PROTO_UDP, 16'd42,   1'b0, ST_OK},
        '{34,  16'h0800, 4'd5,  8'd0,      16'd34,   1'b0, ST_OK},
        '{34,  16'h0800, 4'd5,  8'd255,    16'hFFFF, 1'b0, ST_OK},
        '{94,  16'h0800, 4'd15, PROTO_TCP, 16'd94,   1'b0, ST_OK},
        '{93,  16'h0800, 4'd15, PROTO_TCP, 16'd93,   1'b0, ST_OK},
        '{300, 16'h0800, 4'd6,  PROTO_TCP, 16'hFFFF, 1'b0, ST_OK},
        '{256, 16'h0800, 4'd5,  PROTO_UDP, 16'd0,    1'b0, ST_OK}
    };

    function automatic void clear_capture();
        cap_count = '0;
        etype_acc = '0;
        ihl_acc   = '0;
        src_acc   = '0;
        dst_acc   = '0;
        proto_acc = '0;
        ports_acc = '0;
        flags_acc = '0;
    endfunction

    // one frame byte into the capture state; returns 1 with the summary on tlast
    function automatic bit extract_headers(input logic [7:0] b, input logic last,
                                           input logic [15:0] wl, output t_result r);
        int l4;
        int hlen;
        int caplen;
        r = '0;
        if (cap_count < SNAP_BYTES) begin
            l4 = ETH_HDR + 4 * int'(ihl_acc);
            if (cap_count == 12 || cap_count == 13)
                etype_acc = {etype_acc[7:0], b};
            else if (cap_count == 14)
                ihl_acc = b[3:0];
            else if (cap_count == 23)
                proto_acc = b;
            else if (cap_count >= 26 && cap_count < 30)
                src_acc = {src_acc[23:0], b};
            else if (cap_count >= 30 && cap_count < IP_END)
                dst_acc = {dst_acc[23:0], b};
            if (cap_count >= IP_END) begin
                if (cap_count >= l4 && cap_count < l4 + 4)
                    ports_acc = {ports_acc[23:0], b};
                if (cap_count == l4 + FLAG_OFS)
                    flags_acc = b[5:0];
            end
            cap_count = cap_count + 1'b1;
        end
        if (!last)
            return 1'b0;

        frames_ended = frames_ended + 1;
        caplen = int'(cap_count);
        hlen = 4 * int'(ihl_acc);
        r.frame_len = wl;
        r.frame_num = frames_ended;
        if (caplen < ETH_HDR)
            r.status = ST_SHORT_ETH;
        else if (etype_acc != ETYPE_IPV4)
            r.status = ST_NOT_IPV4;
        else if (caplen < IP_END)
            r.status = ST_SHORT_IP;
        else if (hlen < IP_MIN)
            r.status = ST_BAD_IHL;
        else if (caplen < ETH_HDR + hlen)
            r.status = ST_SHORT_OPT;
        else begin
            r.status   = ST_OK;
            r.src_addr = src_acc;
            r.dst_addr = dst_acc;
            r.protocol = proto_acc;
            if (proto_acc == PROTO_TCP) begin
                if (caplen >= ETH_HDR + hlen + TCP_MIN) begin
                    r.sport     = ports_acc[31:16];
                    r.dport     = ports_acc[15:0];
                    r.tcp_flags = flags_acc;
                end else
                    r.status = ST_L4_TRUNC;
            end else if (proto_acc == PROTO_UDP) begin
                if (caplen >= ETH_HDR + hlen + UDP_MIN) begin
                    r.sport = ports_acc[31:16];
                    r.dport = ports_acc[15:0];
                end else
                    r.status = ST_L4_TRUNC;
            end
        end
        clear_capture();
        return 1'b1;
    endfunction

    // random frame body with the header fields that steer parsing pinned
    function automatic void build_frame(input int len, input logic [15:0] etype,
                                        input logic [3:0] ihl, input logic [7:0] proto);
        logic [7:0] b;
        frame_bytes.delete();
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom);
            case (i)
                12: b = etype[15:8];
                13: b = etype[7:0];
                14: b = {b[7:4], ihl};
                23: b = proto;
                default: ;
            endcase
            frame_bytes.push_back(b);
        end
    endfunction

    task automatic offer_byte(input logic [7:0] b, input logic last, input logic [15:0] wl);
        s_tvalid <= 1'b1;
        s_tdata  <= {wl, b};
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
    endtask

    task automatic send_frame(input logic [15:0] wl, input bit typed, input t_status want,
                              input int row);
        bit      gappy;
        bit      last;
        t_result summary;
        gappy = !quiet && ($urandom_range(0, 2) != 0);
        for (int i = 0; i < frame_bytes.size(); i++) begin
            if (gappy && !quiet && $urandom_range(0, 3) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            last = (i == frame_bytes.size() - 1);
            offer_byte(frame_bytes[i], last, last ? wl : 16'($urandom));
            bytes_sent++;
            if (extract_headers(frame_bytes[i], last, wl, summary)) begin
                if (typed) begin
                    // error rows: everything but status, length and frame number is zero
                    summary           = '0;
                    summary.status    = want;
                    summary.frame_len = wl;
                    summary.frame_num = 32'(row + 1);
                end
                summaries_due.push_back(summary);
            end
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] got,
                                        input logic [31:0] want, input logic [31:0] num);
        if (got !== want) begin
            if (mismatch_count < 10)
                $display("frame %0d %s: expected %0h, got %0h", num, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic check_summary(input logic [2:0] st, input logic [159:0] d);
        t_result want;
        if (summaries_due.size() == 0) begin
            if (mismatch_count < 10)
                $display("unexpected summary: status %0d data %0h", st, d);
            mismatch_count++;
            return;
        end
        want = summaries_due.pop_front();
        summaries_seen++;
        check_field("status",   32'(st),         32'(want.status),    want.frame_num);
        check_field("src_addr", d[31:0],         want.src_addr,       want.frame_num);
        check_field("dst_addr", d[63:32],        want.dst_addr,       want.frame_num);
        check_field("protocol", 32'(d[71:64]),   32'(want.protocol),  want.frame_num);
        check_field("sport",    32'(d[87:72]),   32'(want.sport),     want.frame_num);
        check_field("dport",    32'(d[103:88]),  32'(want.dport),     want.frame_num);
        check_field("frame_len", 32'(d[119:104]), 32'(want.frame_len), want.frame_num);
        check_field("tcp_flags", 32'(d[125:120]), 32'(want.tcp_flags), want.frame_num);
        check_field("frame_num", d[157:126],     want.frame_num,      want.frame_num);
    endtask

    // result sink: random stall bursts, one long hold to back the block up
    initial begin : summary_sink
        int stall_left;
        bit busy;
        bit held;
        stall_left = 0;
        busy = 1'b1;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready)
                check_summary(m_tuser, m_tdata);
            if (stall_left > 0)
                stall_left--;
            else if (!held && !quiet && summaries_seen >= HOLD_AFTER) begin
                held = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (!quiet) begin
                if ($urandom_range(0, 99) == 0)
                    busy = !busy;
                if (busy && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 16);
            end
            m_tready <= (stall_left == 0);
        end
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("ipv4_l4_header_extractor_top_test: FAIL");
        $finish;
    end

    initial begin : frame_source
        int          kind;
        int          len;
        int          l4min;
        int          ihl_n;
        logic [7:0]  proto;
        logic [15:0] etype;
        clear_capture();
        frames_ended = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_frames[k]) begin
            build_frame(directed_frames[k].len, directed_frames[k].etype,
                        directed_frames[k].ihl, directed_frames[k].proto);
            send_frame(directed_frames[k].wire_len, directed_frames[k].typed,
                       directed_frames[k].want, k);
        end

        while (bytes_sent < ITEM_TARGET) begin
            if (bytes_sent >= ITEM_TARGET - QUIET_ITEMS)
                quiet = 1'b1;
            kind = $urandom_range(0, 99);
            etype = ETYPE_IPV4;
            if (kind < 70) begin
                // IPv4 with a valid IHL, mostly minimal header, mostly TCP or UDP
                ihl_n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 15) : 5;
                case ($urandom_range(0, 9))
                    0: proto = 8'($urandom);
                    1, 2, 3, 4: proto = PROTO_UDP;
                    default: proto = PROTO_TCP;
                endcase
                l4min = (proto == PROTO_TCP) ? TCP_MIN : (proto == PROTO_UDP) ? UDP_MIN : 0;
                len = ETH_HDR + 4 * ihl_n + l4min + $urandom_range(0, 12);
                if (l4min > 0 && $urandom_range(0, 6) == 0)
                    len = ETH_HDR + 4 * ihl_n + $urandom_range(0, l4min - 1);
                if ($urandom_range(0, 49) == 0)
                    len = $urandom_range(250, 320);
            end else if (kind < 85) begin
                ihl_n = $urandom_range(0, 15);
                proto = 8'($urandom);
                len = $urandom_range(1, 60);
            end else begin
                ihl_n = $urandom_range(0, 15);
                proto = 8'($urandom);
                etype = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'h0800;
                len = $urandom_range(1, 40);
            end
            build_frame(len, etype, 4'(ihl_n), proto);
            send_frame(16'($urandom), 1'b0, ST_OK, 0);
        end
        s_tvalid <= 1'b0;

        while (summaries_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && summaries_due.size() == 0)
            $display("ipv4_l4_header_extractor_top_test: PASS");
        else
            $display("ipv4_l4_header_extractor_top_test: FAIL");
        $finish;
    end

endmodule
